// ===== hw/rtl/lrbt_pkg.sv =====
// shared types, register codes and constants of the reconnect backoff timer
`timescale 1ns / 1ps

package lrbt_pkg;

	// action codes of a result word
	localparam logic [2:0] ACT_SKIP       = 3'd0;
	localparam logic [2:0] ACT_OK         = 3'd1;
	localparam logic [2:0] ACT_FIRST_DROP = 3'd2;
	localparam logic [2:0] ACT_WAIT       = 3'd3;
	localparam logic [2:0] ACT_RETRY      = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RETRY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_BACKOFF   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF    = 2'd3;
	localparam int unsigned CFG_DATA_W = 16;

	// register values after reset
	localparam logic [15:0] RST_CHECK_INTERVAL = 16'd2000;
	localparam logic [15:0] RST_FIRST_RETRY    = 16'd5000;
	localparam logic [7:0]  RST_INIT_BACKOFF   = 8'd5;
	localparam logic [7:0]  RST_MAX_BACKOFF    = 8'd120;

	// milliseconds per second, and floor(x / 1000) as (x * magic) >> shift for 32-bit x
	localparam logic [9:0]  MS_PER_S     = 10'd1000;
	localparam int unsigned DIV_MAGIC_W  = 29;
	localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;
	localparam int unsigned DIV_SHIFT    = 38;
	localparam int unsigned DIV_PROD_W   = 32 + DIV_MAGIC_W;

	typedef struct packed {
		logic [15:0] check_interval_ms;
		logic [15:0] first_retry_ms;
		logic [7:0]  initial_backoff_s;
		logic [7:0]  max_backoff_s;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        link_up;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  action;
		logic        start_clock_sync;
		logic [7:0]  backoff_s;
		logic [22:0] down_seconds;
	} out_word_t;

	// decision stage result, elapsed down time still in milliseconds
	typedef struct packed {
		logic [2:0]  action;
		logic        start_clock_sync;
		logic [7:0]  backoff_s;
		logic [31:0] down_ms;
	} dec_word_t;

endpackage

// ===== hw/rtl/lrbt_cfg_regs.sv =====
// configuration registers with their reset values
`timescale 1ns / 1ps

module lrbt_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [lrbt_pkg::CFG_IDX_W-1:0]      idx,
	input  logic [lrbt_pkg::CFG_DATA_W-1:0]     wdata,
	output lrbt_pkg::cfg_t                      cfg
);
	import lrbt_pkg::*;

	cfg_t cfg_q;

	// register write, narrow registers keep the low bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval_ms <= RST_CHECK_INTERVAL;
			cfg_q.first_retry_ms    <= RST_FIRST_RETRY;
			cfg_q.initial_backoff_s <= RST_INIT_BACKOFF;
			cfg_q.max_backoff_s     <= RST_MAX_BACKOFF;
		end else if (we) begin
			unique case (idx)
				CFG_CHECK_INTERVAL: cfg_q.check_interval_ms <= wdata;
				CFG_FIRST_RETRY:    cfg_q.first_retry_ms    <= wdata;
				CFG_INIT_BACKOFF:   cfg_q.initial_backoff_s <= wdata[7:0];
				CFG_MAX_BACKOFF:    cfg_q.max_backoff_s     <= wdata[7:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/lrbt_poll_core.sv =====
// poll decision logic, supervisor state and decision stage register
`timescale 1ns / 1ps

module lrbt_poll_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrbt_pkg::cfg_t        cfg,
	input  lrbt_pkg::in_word_t    item_s1,
	input  logic                  take,
	output lrbt_pkg::dec_word_t   res_s2
);
	import lrbt_pkg::*;

	logic [31:0] last_check_q;
	logic        is_down_q;
	logic [31:0] down_since_q;
	logic [31:0] retry_at_q;
	logic [7:0]  backoff_q;
	logic        clock_started_q;

	logic [31:0] last_check_d;
	logic        is_down_d;
	logic [31:0] down_since_d;
	logic [31:0] retry_at_d;
	logic [7:0]  backoff_d;
	logic        clock_started_d;

	logic [31:0] elapsed;
	logic [31:0] past_retry;
	logic        skip;
	logic        reached;
	logic [8:0]  want;
	logic [7:0]  next_backoff;
	logic [17:0] backoff_ms;
	dec_word_t   res_d;
	dec_word_t   res_q_s2;

	// interval gate, wrap-safe retry check and backoff step
	always_comb begin
		elapsed      = item_s1.now_ms - last_check_q;
		skip         = elapsed < {16'd0, cfg.check_interval_ms};
		past_retry   = item_s1.now_ms - retry_at_q;
		reached      = !past_retry[31];
		want         = (backoff_q == 8'd0) ? {1'b0, cfg.initial_backoff_s}
		                                   : {backoff_q, 1'b0};
		next_backoff = (want < {1'b0, cfg.max_backoff_s}) ? want[7:0]
		                                                   : cfg.max_backoff_s;
		backoff_ms   = {10'd0, next_backoff} * {8'd0, MS_PER_S};
	end

	// next state and result word
	always_comb begin
		last_check_d    = last_check_q;
		is_down_d       = is_down_q;
		down_since_d    = down_since_q;
		retry_at_d      = retry_at_q;
		backoff_d       = backoff_q;
		clock_started_d = clock_started_q;
		res_d.action           = ACT_SKIP;
		res_d.start_clock_sync = 1'b0;
		res_d.down_ms          = 32'd0;
		priority if (skip) begin
			res_d.action = ACT_SKIP;
		end else if (item_s1.link_up) begin
			last_check_d    = item_s1.now_ms;
			res_d.action    = ACT_OK;
			is_down_d       = 1'b0;
			backoff_d       = 8'd0;
			clock_started_d = 1'b1;
			res_d.start_clock_sync = !clock_started_q;
		end else if (!is_down_q) begin
			last_check_d = item_s1.now_ms;
			res_d.action = ACT_FIRST_DROP;
			is_down_d    = 1'b1;
			down_since_d = item_s1.now_ms;
			retry_at_d   = item_s1.now_ms + {16'd0, cfg.first_retry_ms};
		end else if (reached) begin
			last_check_d  = item_s1.now_ms;
			res_d.action  = ACT_RETRY;
			res_d.down_ms = item_s1.now_ms - down_since_q;
			backoff_d     = next_backoff;
			retry_at_d    = item_s1.now_ms + {14'd0, backoff_ms};
		end else begin
			last_check_d = item_s1.now_ms;
			res_d.action = ACT_WAIT;
		end
		res_d.backoff_s = backoff_d;
	end

	// supervisor state, updated as a word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_check_q    <= 32'd0;
			is_down_q       <= 1'b0;
			down_since_q    <= 32'd0;
			retry_at_q      <= 32'd0;
			backoff_q       <= 8'd0;
			clock_started_q <= 1'b0;
		end else if (take) begin
			last_check_q    <= last_check_d;
			is_down_q       <= is_down_d;
			down_since_q    <= down_since_d;
			retry_at_q      <= retry_at_d;
			backoff_q       <= backoff_d;
			clock_started_q <= clock_started_d;
		end
	end

	// decision stage register
	always_ff @(posedge clk) begin
		if (take) begin
			res_q_s2 <= res_d;
		end
	end

	assign res_s2 = res_q_s2;

	// clock sync request is sticky once made
	a_sync_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		clock_started_q |=> clock_started_q)
		else $error("clock sync flag cleared");

	// a first drop leaves the link marked down
	a_drop_marks_down: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_d.action == ACT_FIRST_DROP |=> is_down_q)
		else $error("first drop did not set down state");

	// a retry never leaves the backoff above the ceiling
	a_backoff_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_d.action == ACT_RETRY |=> backoff_q <= $past(cfg.max_backoff_s))
		else $error("backoff above ceiling after retry");

	// the clock sync is only requested on a link-ok word
	a_sync_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_d.start_clock_sync |-> res_d.action == ACT_OK && !clock_started_q)
		else $error("clock sync requested outside first link-ok poll");

endmodule

// ===== hw/rtl/lrbt_sec_div.sv =====
// millisecond to whole-second conversion and output register
`timescale 1ns / 1ps

module lrbt_sec_div (
	input  logic                 clk,
	input  lrbt_pkg::dec_word_t  res_s2,
	input  logic                 load,
	output lrbt_pkg::out_word_t  word_s3
);
	import lrbt_pkg::*;

	logic [DIV_PROD_W-1:0] prod;
	out_word_t             word_d;
	out_word_t             word_q_s3;

	// floor(ms / 1000) by reciprocal multiply, exact over 32 bits
	always_comb begin
		prod = {{DIV_MAGIC_W{1'b0}}, res_s2.down_ms}
		     * {{32{1'b0}}, DIV_MAGIC};
		word_d.action           = res_s2.action;
		word_d.start_clock_sync = res_s2.start_clock_sync;
		word_d.backoff_s        = res_s2.backoff_s;
		word_d.down_seconds     = prod[DIV_SHIFT +: 23];
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			word_q_s3 <= word_d;
		end
	end

	assign word_s3 = word_q_s3;

endmodule

// ===== hw/rtl/link_reconnect_backoff_timer.sv =====
// Reconnect supervisor with exponential backoff, top level.
// Pipeline: an accepted word passes the input register, the decision register and the output
// register in that order before it shows at the output.
// Throughput: one poll per cycle unless the output stalls, set by the decision-stage state update.
// Reset: arst_n clears the supervisor state and pipeline valid bits and loads the register defaults.
`timescale 1ns / 1ps

module link_reconnect_backoff_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lrbt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [lrbt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lrbt_pkg::in_word_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lrbt_pkg::out_word_t               out_data
);
	import lrbt_pkg::*;

	cfg_t      cfg;
	in_word_t  item_s1;
	dec_word_t res_s2;
	out_word_t word_s3;

	logic valid_s1_q;
	logic valid_s2_q;
	logic valid_s3_q;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic adv_s1;
	logic adv_s2;

	lrbt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// stage handshake, a stage takes a word when empty or emptying
	always_comb begin
		ready_s3 = !valid_s3_q || out_ready;
		adv_s2   = valid_s2_q && ready_s3;
		ready_s2 = !valid_s2_q || ready_s3;
		adv_s1   = valid_s1_q && ready_s2;
		ready_s1 = !valid_s1_q || ready_s2;
	end

	assign in_ready = ready_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
			valid_s3_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1_q <= in_valid;
			end
			if (ready_s2) begin
				valid_s2_q <= valid_s1_q;
			end
			if (ready_s3) begin
				valid_s3_q <= valid_s2_q;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			item_s1 <= in_data;
		end
	end

	lrbt_poll_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_s1 (item_s1),
		.take    (adv_s1),
		.res_s2  (res_s2)
	);

	lrbt_sec_div u_div (
		.clk     (clk),
		.res_s2  (res_s2),
		.load    (adv_s2),
		.word_s3 (word_s3)
	);

	assign out_valid = valid_s3_q;
	assign out_data  = word_s3;

	// down time is only reported with a retry
	a_down_only_retry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action != ACT_RETRY |-> out_data.down_seconds == 23'd0)
		else $error("down time reported without retry");

	// a stalled output stage blocks intake once the pipe is full
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1_q && valid_s2_q && valid_s3_q && !out_ready |-> !in_ready)
		else $error("word taken into a full pipeline");

	// a word leaving the decision stage always lands in the output stage
	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> valid_s3_q)
		else $error("decided word lost before output");

endmodule

// ===== bench/lrbt_checker.sv =====
// checker of the reconnect backoff timer: predicts each result word and compares it
`timescale 1ns / 1ps

module lrbt_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lrbt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lrbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  lrbt_pkg::in_word_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  lrbt_pkg::out_word_t             out_data,
	output int                              errors,
	output int                              pending
);
	import lrbt_pkg::*;

	// own copy of the registers and the supervisor state
	cfg_t        regs;
	logic [31:0] last_handled;
	logic        link_lost;
	logic [31:0] lost_at;
	logic [31:0] retry_due;
	logic [7:0]  backoff_now;
	logic        sync_sent;

	out_word_t   expected_results [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// one poll through the supervisor, updating the state copy
	task automatic predict_poll(input in_word_t poll, output out_word_t res);
		logic [31:0] elapsed;
		logic [31:0] past_due;
		logic [31:0] down_ms;
		logic [8:0]  doubled;
		res = '0;
		elapsed = poll.now_ms - last_handled;
		if (elapsed < 32'(regs.check_interval_ms)) begin
			res.action = ACT_SKIP;
		end else begin
			last_handled = poll.now_ms;
			past_due = poll.now_ms - retry_due;
			if (poll.link_up) begin
				res.action = ACT_OK;
				link_lost = 1'b0;
				backoff_now = '0;
				if (!sync_sent) begin
					sync_sent = 1'b1;
					res.start_clock_sync = 1'b1;
				end
			end else if (!link_lost) begin
				res.action = ACT_FIRST_DROP;
				link_lost = 1'b1;
				lost_at = poll.now_ms;
				retry_due = poll.now_ms + 32'(regs.first_retry_ms);
			end else if (!past_due[31]) begin
				// retry time reached: step the backoff and reschedule
				res.action = ACT_RETRY;
				down_ms = poll.now_ms - lost_at;
				res.down_seconds = 23'(down_ms / 32'd1000);
				doubled = (backoff_now == 8'd0) ? {1'b0, regs.initial_backoff_s}
					: {backoff_now, 1'b0};
				backoff_now = (doubled < {1'b0, regs.max_backoff_s}) ? doubled[7:0]
					: regs.max_backoff_s;
				retry_due = poll.now_ms + 32'(backoff_now) * 32'd1000;
			end else begin
				res.action = ACT_WAIT;
			end
		end
		res.backoff_s = backoff_now;
	endtask

	// compare result words, follow register writes, then predict new polls
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t fresh;
		if (!arst_n) begin
			regs = '{RST_CHECK_INTERVAL, RST_FIRST_RETRY, RST_INIT_BACKOFF, RST_MAX_BACKOFF};
			last_handled = '0;
			link_lost    = 1'b0;
			lost_at      = '0;
			retry_due    = '0;
			backoff_now  = '0;
			sync_sent    = 1'b0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with no poll waiting",
						32'(out_data.action), 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.action !== want.action)
						report_mismatch("action", 32'(out_data.action), 32'(want.action));
					if (out_data.start_clock_sync !== want.start_clock_sync)
						report_mismatch("start_clock_sync", 32'(out_data.start_clock_sync),
							32'(want.start_clock_sync));
					if (out_data.backoff_s !== want.backoff_s)
						report_mismatch("backoff_s", 32'(out_data.backoff_s),
							32'(want.backoff_s));
					if (out_data.down_seconds !== want.down_seconds)
						report_mismatch("down_seconds", 32'(out_data.down_seconds),
							32'(want.down_seconds));
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_CHECK_INTERVAL: regs.check_interval_ms = cfg_wdata;
					CFG_FIRST_RETRY:    regs.first_retry_ms    = cfg_wdata;
					CFG_INIT_BACKOFF:   regs.initial_backoff_s = cfg_wdata[7:0];
					CFG_MAX_BACKOFF:    regs.max_backoff_s     = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_poll(in_data, fresh);
				expected_results.push_back(fresh);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== bench/tb_link_reconnect_backoff_timer.sv =====
// testbench top of the reconnect backoff timer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_link_reconnect_backoff_timer;
	import lrbt_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_CHECK_INTERVAL;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_word_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;

	int          errors;
	int          pending;
	logic        in_taken    = 1'b0;
	int          burst_left  = 0;
	logic [15:0] interval_now = RST_CHECK_INTERVAL;
	logic [7:0]  rx_tick     = '0;
	int          quiet_cycles = 0;

	// directed polls: early polls, every action, doubling to the ceiling, wrap of time
	in_word_t warm_polls [17] = '{
		{32'd0, 1'b1}, {32'd1999, 1'b0}, {32'd2000, 1'b1}, {32'd4000, 1'b1},
		{32'd6000, 1'b0}, {32'd8000, 1'b0}, {32'd11000, 1'b0}, {32'd16000, 1'b0},
		{32'd26000, 1'b0}, {32'd46000, 1'b0}, {32'd86000, 1'b0}, {32'd166000, 1'b0},
		{32'd286000, 1'b0}, {32'd288000, 1'b1}, {32'hFFFF_F000, 1'b0},
		{32'hFFFF_F800, 1'b0}, {32'h0000_0A00, 1'b0}
	};
	// zero registers: every poll handled, drop at time zero, zero backoff
	in_word_t zero_polls [4] = '{
		{32'd5, 1'b1}, {32'd0, 1'b0}, {32'd0, 1'b0}, {32'd1, 1'b0}
	};
	// full registers: longest interval and first retry, backoff straight to the ceiling
	in_word_t full_polls [3] = '{
		{32'h8000_0000, 1'b1}, {32'h8000_FFFF, 1'b0}, {32'h8001_FFFE, 1'b0}
	};

	link_reconnect_backoff_timer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	lrbt_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// poll word handshake as seen at the rising edge
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
	end

	// receiver stalls: steady, light, periodic and heavy stretches
	always @(negedge clk) begin
		rx_tick <= rx_tick + 8'd1;
		case (rx_tick[7:6])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 3) != 0);
			2'd2: out_ready <= (rx_tick[2:0] != 3'd0);
			default: out_ready <= ($urandom_range(0, 2) == 0);
		endcase
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one poll word, in bursts with gaps between them
	task automatic send_poll(input logic [31:0] stamp, input logic up);
		if (burst_left == 0) begin
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4))
				@(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data  <= '{now_ms: stamp, link_up: up};
		do @(negedge clk); while (!in_taken);
		burst_left--;
		if (burst_left == 0)
			in_valid <= 1'b0;
	endtask

	// stop sending and wait for every outstanding result word
	task automatic drain_results();
		if (burst_left != 0) begin
			in_valid <= 1'b0;
			burst_left = 0;
		end
		while (pending != 0)
			@(negedge clk);
	endtask

	// write all four registers while the block is idle
	task automatic load_registers(input logic [15:0] interval, input logic [15:0] first_retry,
		input logic [7:0] init_backoff, input logic [7:0] max_backoff);
		logic [CFG_DATA_W-1:0] vals [4];
		logic [CFG_IDX_W-1:0]  idxs [4];
		vals = '{interval, first_retry, {8'($urandom), init_backoff},
			{8'($urandom), max_backoff}};
		idxs = '{CFG_CHECK_INTERVAL, CFG_FIRST_RETRY, CFG_INIT_BACKOFF, CFG_MAX_BACKOFF};
		drain_results();
		for (int k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= idxs[k];
			cfg_wdata <= vals[k];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		interval_now = interval;
	endtask

	// random polls: time mostly walks forward around the interval, link drops in long runs
	task automatic random_polls(input int count);
		logic [31:0] stamp;
		logic        up;
		int          pick;
		stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400000)
			: $urandom;
		up = 1'($urandom_range(0, 1));
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				stamp = stamp + $urandom_range(0, interval_now);
			else if (pick < 55)
				stamp = stamp + interval_now + $urandom_range(0, interval_now);
			else if (pick < 75)
				stamp = stamp + $urandom_range(0, 300000);
			else if (pick < 95)
				stamp = stamp + $urandom_range(0, 70000);
			else
				stamp = $urandom;
			if (up)
				up = ($urandom_range(0, 5) != 0);
			else
				up = ($urandom_range(0, 14) == 0);
			send_poll(stamp, up);
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (warm_polls[i])
			send_poll(warm_polls[i].now_ms, warm_polls[i].link_up);
		load_registers(16'd0, 16'd0, 8'd0, 8'd0);
		foreach (zero_polls[i])
			send_poll(zero_polls[i].now_ms, zero_polls[i].link_up);
		load_registers(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
		foreach (full_polls[i])
			send_poll(full_polls[i].now_ms, full_polls[i].link_up);

		// random phases over several register settings
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: load_registers(RST_CHECK_INTERVAL, RST_FIRST_RETRY, RST_INIT_BACKOFF,
					RST_MAX_BACKOFF);
				1: load_registers(16'd0, 16'd0, 8'd0, 8'd0);
				2: load_registers(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
				3: load_registers(16'd1, 16'd1, 8'd1, 8'd1);
				4: load_registers(16'd1000, 16'd0, 8'hFF, 8'd1);
				5: load_registers(16'd500, 16'hFFFF, 8'd1, 8'hFF);
				default: load_registers(16'($urandom_range(0, 4000)), 16'($urandom),
					8'($urandom), 8'($urandom));
			endcase
			random_polls(190);
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
